### sv/fau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction arithmetic unit package
// Shared widths, action codes, status codes and the control bundle that the
// sequencer hands to the cross-product stage.
// ----------------------------------------------------------------------------
package fau_pkg;

    // Operand numerator width; denominators are one bit narrower
    localparam int WIDTH = 16;
    localparam int DW    = WIDTH - 1;

    // Product, sum and magnitude widths
    localparam int PW = 2 * WIDTH;
    localparam int NW = PW + 1;
    localparam int MW = 2 * WIDTH;
    localparam int SW = MW + 1;
    localparam int CW = $clog2(MW);

    // Fixed result field widths
    localparam int RES_NUM_W = 32;
    localparam int RES_DEN_W = 31;
    localparam int XW        = (MW > RES_NUM_W) ? MW : RES_NUM_W;

    localparam int ACT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_MUL = 3'd0,
        ACT_DIV = 3'd1,
        ACT_ADD = 3'd2,
        ACT_SUB = 3'd3,
        ACT_CMP = 3'd4
    } t_action;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    // Cross-product stage loads
    typedef struct packed {
        logic load_first;
        logic load_second;
    } t_xp_ctl;

endpackage
`default_nettype wire

### sv/fau_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared subtractor
// One wide subtract with a greater-or-equal flag; serves both the GCD loop
// and the restoring quotient loop.
// ----------------------------------------------------------------------------
module fau_sub import fau_pkg::*; (
    input  wire logic [SW-1:0] i_x,
    input  wire logic [SW-1:0] i_y,
    output logic      [SW-1:0] o_diff,
    output logic               o_ge
);

    logic borrow;

    // Subtract with one extra bit to catch the borrow
    assign {borrow, o_diff} = {1'b0, i_x} - {1'b0, i_y};
    assign o_ge             = ~borrow;

endmodule
`default_nettype wire

### sv/fau_xprod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cross-product stage
// Two multipliers with registered outputs. The first load forms the
// products for the action; the second load folds them into a sum or
// difference and forms the common denominator.
// ----------------------------------------------------------------------------
module fau_xprod import fau_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_xp_ctl                 i_ctl,
    input  wire logic [ACT_W-1:0]        i_action,
    input  wire logic signed [WIDTH-1:0] i_ln,
    input  wire logic [DW-1:0]           i_ld,
    input  wire logic signed [WIDTH-1:0] i_rn,
    input  wire logic [DW-1:0]           i_rd,
    output logic signed [NW-1:0]         o_num,
    output logic signed [PW-1:0]         o_den
);

    logic signed [WIDTH-1:0] w_ld_s;
    logic signed [WIDTH-1:0] w_rd_s;
    logic signed [WIDTH-1:0] w_opa;
    logic signed [WIDTH-1:0] w_opb;
    logic signed [PW-1:0]    w_pa;
    logic signed [PW-1:0]    w_pb;
    logic signed [NW-1:0]    r_num;
    logic signed [PW-1:0]    r_den;

    assign w_ld_s = signed'({1'b0, i_ld});
    assign w_rd_s = signed'({1'b0, i_rd});

    // Pick multiplier operands: multiply pairs like terms, the rest cross; the second load pairs the denominators
    always_comb begin
        w_opa = (i_action == ACT_MUL) ? i_rn : w_rd_s;
        w_opb = ((i_action == ACT_MUL) || i_ctl.load_second) ? w_rd_s : i_rn;
    end

    assign w_pa = i_ln * w_opa;
    assign w_pb = w_ld_s * w_opb;

    // Hold products; fold into sum or difference on the second load
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_first) begin
            r_num <= {w_pa[PW-1], w_pa};
            r_den <= w_pb;
        end else if (i_ctl.load_second) begin
            if (i_action == ACT_SUB) begin
                r_num <= r_num - {r_den[PW-1], r_den};
            end else begin
                r_num <= r_num + {r_den[PW-1], r_den};
            end
            r_den <= w_pb;
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule
`default_nettype wire

### sv/fraction_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fraction arithmetic unit
// Multiplies, divides, adds, subtracts or compares two fractions and reduces
// the result to lowest terms with a binary GCD and two restoring divisions.
//
//   channel   handshake          payload
//   command   start / busy       i_action, i_left_*, i_right_*
//   result    o_done (1 cycle)   o_result_numerator, o_result_denominator,
//                                o_equal_flag, o_status
//
// An item is taken when start is high and busy is low; busy stays high until
// the cycle its result is strobed. Compare, unused actions, zero results and
// division by zero finish in setup, after the cross products. Reduced results
// strip common factors of two, run the GCD shifts, subtracts and swaps, then
// form the two quotients bit by bit. The single shared subtractor sets the
// pace. Reset is synchronous and returns the sequencer to idle. The receiver
// cannot stall; o_done is high for exactly one cycle, and the result fields
// hold until the next item reaches setup.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit import fau_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ACT_W-1:0]            i_action,
    input  wire logic signed [WIDTH-1:0]     i_left_numerator,
    input  wire logic [DW-1:0]               i_left_denominator,
    input  wire logic signed [WIDTH-1:0]     i_right_numerator,
    input  wire logic [DW-1:0]               i_right_denominator,
    output logic                             o_done,
    output logic signed [RES_NUM_W-1:0]      o_result_numerator,
    output logic [RES_DEN_W-1:0]             o_result_denominator,
    output logic                             o_equal_flag,
    output logic                             o_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_STRIP,
        ST_GCD,
        ST_DIVN,
        ST_DIVD
    } t_state;

    t_state                  r_state;
    logic [ACT_W-1:0]        r_act;
    logic signed [WIDTH-1:0] r_ln;
    logic [DW-1:0]           r_ld;
    logic signed [WIDTH-1:0] r_rn;
    logic [DW-1:0]           r_rd;
    logic [MW-1:0]           r_a;
    logic [MW-1:0]           r_b;
    logic [MW-1:0]           r_na;
    logic [MW-1:0]           r_da;
    logic [CW-1:0]           r_cnt;
    logic                    r_neg;
    logic                    r_done;
    logic signed [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0]    r_res_den;
    logic                    r_eq;
    logic                    r_status;

    t_xp_ctl                 w_xp_ctl;
    logic signed [NW-1:0]    w_num;
    logic signed [PW-1:0]    w_den;
    logic                    w_num_neg;
    logic                    w_den_neg;
    logic signed [NW-1:0]    w_num_abs;
    logic signed [PW-1:0]    w_den_abs;
    logic                    w_cross_eq;
    logic                    w_short;
    logic                    w_finish;
    logic                    w_div_bit;
    logic [SW-1:0]           w_sub_x;
    logic [SW-1:0]           w_sub_y;
    logic [SW-1:0]           w_diff;
    logic                    w_ge;
    logic                    w_last;
    logic [MW-1:0]           w_qd;
    logic [XW-1:0]           w_nx;
    logic [XW-1:0]           w_nsg;
    logic [XW-1:0]           w_dx;

    // Cross products
    assign w_xp_ctl.load_first  = (r_state == ST_MUL1);
    assign w_xp_ctl.load_second = (r_state == ST_MUL2);

    fau_xprod u_xprod (
        .i_clk    (i_clk),
        .i_ctl    (w_xp_ctl),
        .i_action (r_act),
        .i_ln     (r_ln),
        .i_ld     (r_ld),
        .i_rn     (r_rn),
        .i_rd     (r_rd),
        .o_num    (w_num),
        .o_den    (w_den)
    );

    // Move signs off the raw result; magnitudes feed the reduction
    assign w_num_neg  = w_num[NW-1];
    assign w_den_neg  = w_den[PW-1];
    assign w_num_abs  = w_num_neg ? -w_num : w_num;
    assign w_den_abs  = w_den_neg ? -w_den : w_den;
    assign w_cross_eq = (w_num == {w_den[PW-1], w_den});

    // Finish in setup for compare, unused actions, errors and zero results
    assign w_short  = (r_act >= ACT_CMP) || (w_den == '0) || (w_num == '0);
    assign w_finish = ((r_state == ST_PREP) && w_short) ||
                      ((r_state == ST_DIVD) && w_last);

    // Shared subtractor: GCD compares a with b, quotient loops trial-subtract
    assign w_div_bit = (r_state == ST_DIVD) ? r_da[MW-1] : r_na[MW-1];
    assign w_sub_x   = (r_state == ST_GCD) ? {1'b0, r_a} : {r_a, w_div_bit};
    assign w_sub_y   = {1'b0, r_b};

    fau_sub u_sub (
        .i_x    (w_sub_x),
        .i_y    (w_sub_y),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // Final result fields from the quotients
    assign w_last = (r_cnt == CW'(MW - 1));
    assign w_qd   = {r_da[MW-2:0], w_ge};
    assign w_nx   = XW'(r_na);
    assign w_nsg  = r_neg ? -w_nx : w_nx;
    assign w_dx   = XW'(w_qd);

    // Sequencer, datapath registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_finish;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_act   <= i_action;
                        r_ln    <= i_left_numerator;
                        r_ld    <= i_left_denominator;
                        r_rn    <= i_right_numerator;
                        r_rd    <= i_right_denominator;
                        r_state <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    if ((r_act == ACT_ADD) || (r_act == ACT_SUB)) begin
                        r_state <= ST_MUL2;
                    end else begin
                        r_state <= ST_PREP;
                    end
                end
                ST_MUL2: begin
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    // Error only for arithmetic actions with a zero denominator
                    r_res_num <= '0;
                    r_res_den <= RES_DEN_W'(1);
                    r_eq      <= (r_act == ACT_CMP) && w_cross_eq;
                    r_status  <= ((r_act < ACT_CMP) && (w_den == '0)) ?
                                 ST_DIV_ZERO : ST_OK;
                    r_neg     <= w_num_neg ^ w_den_neg;
                    r_a       <= w_num_abs[MW-1:0];
                    r_na      <= w_num_abs[MW-1:0];
                    r_b       <= w_den_abs[MW-1:0];
                    r_da      <= w_den_abs[MW-1:0];
                    if (w_short) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_STRIP;
                    end
                end
                ST_STRIP: begin
                    // Drop common factors of two from both terms
                    if (!r_a[0] && !r_b[0]) begin
                        r_a  <= r_a >> 1;
                        r_b  <= r_b >> 1;
                        r_na <= r_na >> 1;
                        r_da <= r_da >> 1;
                    end else begin
                        r_state <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    // Binary GCD of the odd part; b ends holding the divisor
                    priority if (r_a == '0) begin
                        r_cnt   <= '0;
                        r_state <= ST_DIVN;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (w_ge) begin
                        r_a <= w_diff[MW:1];
                    end else begin
                        r_a <= r_b;
                        r_b <= r_a;
                    end
                end
                ST_DIVN: begin
                    // Restoring division of the numerator, one bit a cycle
                    r_na <= {r_na[MW-2:0], w_ge};
                    if (w_last) begin
                        r_a     <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIVD;
                    end else begin
                        r_a   <= w_ge ? w_diff[MW-1:0] : w_sub_x[MW-1:0];
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_DIVD: begin
                    // Same for the denominator, then emit the result
                    r_a   <= w_ge ? w_diff[MW-1:0] : w_sub_x[MW-1:0];
                    r_da  <= w_qd;
                    r_cnt <= r_cnt + CW'(1);
                    if (w_last) begin
                        r_res_num <= signed'(w_nsg[RES_NUM_W-1:0]);
                        r_res_den <= w_dx[RES_DEN_W-1:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy                 = (r_state != ST_IDLE);
    assign o_done               = r_done;
    assign o_result_numerator   = r_res_num;
    assign o_result_denominator = r_res_den;
    assign o_equal_flag         = r_eq;
    assign o_status             = r_status;

    // Checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == ST_IDLE))
        else $error("result strobed while sequencer still working");

    a_gcd_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> (r_b != '0))
        else $error("GCD divisor register reached zero");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_DIV_ZERO)) |->
            ((o_result_numerator == '0) && (o_result_denominator == RES_DEN_W'(1))))
        else $error("division by zero did not give 0/1");

    a_eq_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_equal_flag) |-> (o_status == ST_OK))
        else $error("equal flag raised with error status");

endmodule
`default_nettype wire
